// ===== design/hk2fw_pkg.sv =====
// ----------------------------------------------------------------------------
// hk2fw_pkg: shared types and constants for the half-width kana converter
// Holds the item structs, the queue entry format, the voicing-mark codes and
// the half-width to full-width Shift-JIS lookup tables.
// ----------------------------------------------------------------------------
package hk2fw_pkg;

    // Input item: a data byte or an end-of-stream marker.
    typedef struct packed {
        logic       kind;
        logic [7:0] code_byte;
    } t_in_item;

    // Result item: one full-width pair or one flagged byte.
    typedef struct packed {
        logic [7:0] lead_byte;
        logic [7:0] trail_byte;
        logic       bad_byte;
        logic       last;
    } t_out_item;

    // Input item kinds.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Voicing mark folded into an emitted kana.
    typedef enum logic [1:0] {
        MARK_NONE  = 2'd0,
        MARK_VOICE = 2'd1,
        MARK_SEMI  = 2'd2
    } t_mark;

    // Work for the back part: an optional kana emit, then an optional flag.
    typedef struct packed {
        logic       has_kana;
        logic [5:0] kana_idx;
        t_mark      mark;
        logic       has_bad;
        logic [7:0] bad_byte;
    } t_op;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Stream byte values.
    localparam logic [7:0] KANA_LO     = 8'd161;
    localparam logic [7:0] KANA_HI     = 8'd223;
    localparam logic [7:0] BYTE_VOICE  = 8'd222;
    localparam logic [7:0] BYTE_SEMI   = 8'd223;
    localparam logic [7:0] BYTE_PREFIX = 8'd142;

    // Half-width kana that accept a voicing or semi-voicing mark.
    localparam logic [7:0] VOICE_A_LO = 8'd182;
    localparam logic [7:0] VOICE_A_HI = 8'd196;
    localparam logic [7:0] VOICE_B_LO = 8'd202;
    localparam logic [7:0] VOICE_B_HI = 8'd206;
    localparam logic [7:0] KANA_U     = 8'd179;

    // Full-width trail byte ranges that the marks shift.
    localparam logic [7:0] TRAIL_A_LO = 8'd74;
    localparam logic [7:0] TRAIL_A_HI = 8'd103;
    localparam logic [7:0] TRAIL_B_LO = 8'd110;
    localparam logic [7:0] TRAIL_B_HI = 8'd122;
    localparam logic [7:0] LEAD_KATA  = 8'd131;
    localparam logic [7:0] TRAIL_U    = 8'd69;
    localparam logic [7:0] TRAIL_VU   = 8'd148;

    localparam int KANA_COUNT = 63;

    localparam logic [7:0] LEAD_TAB [KANA_COUNT] = '{
        8'd129, 8'd129, 8'd129, 8'd129, 8'd129, 8'd131, 8'd131, 8'd131,
        8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd129,
        8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131,
        8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131,
        8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131,
        8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131,
        8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131,
        8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd129, 8'd129
    };

    localparam logic [7:0] TRAIL_TAB [KANA_COUNT] = '{
        8'd66,  8'd117, 8'd118, 8'd65,  8'd69,  8'd146, 8'd64,  8'd66,
        8'd68,  8'd70,  8'd72,  8'd131, 8'd133, 8'd135, 8'd98,  8'd91,
        8'd65,  8'd67,  8'd69,  8'd71,  8'd73,  8'd74,  8'd76,  8'd78,
        8'd80,  8'd82,  8'd84,  8'd86,  8'd88,  8'd90,  8'd92,  8'd94,
        8'd96,  8'd99,  8'd101, 8'd103, 8'd105, 8'd106, 8'd107, 8'd108,
        8'd109, 8'd110, 8'd113, 8'd116, 8'd119, 8'd122, 8'd125, 8'd126,
        8'd128, 8'd129, 8'd130, 8'd132, 8'd134, 8'd136, 8'd137, 8'd138,
        8'd139, 8'd140, 8'd141, 8'd143, 8'd147, 8'd74,  8'd75
    };

    // Lead byte for a kana index; the unused top index reads as the first.
    function automatic logic [7:0] kana_lead(input logic [5:0] idx);
        logic [7:0] val;
        if (idx == 6'(KANA_COUNT)) begin
            val = LEAD_TAB[0];
        end else begin
            val = LEAD_TAB[idx];
        end
        return val;
    endfunction

    // Trail byte for a kana index; the unused top index reads as the first.
    function automatic logic [7:0] kana_trail(input logic [5:0] idx);
        logic [7:0] val;
        if (idx == 6'(KANA_COUNT)) begin
            val = TRAIL_TAB[0];
        end else begin
            val = TRAIL_TAB[idx];
        end
        return val;
    endfunction

endpackage

// ===== design/hk2fw_front.sv =====
// ----------------------------------------------------------------------------
// hk2fw_front: input acceptance and classification
// Tracks the held kana and the EUC prefix, decides for each input item which
// results it causes, and pushes that work into the queue.
// ----------------------------------------------------------------------------
module hk2fw_front
    import hk2fw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic     i_cfg_data,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_data,
    input  logic     i_q_full,
    output logic     o_push,
    output t_op      o_op
);

    logic       r_mode;
    logic       r_pend_valid;
    logic [7:0] r_pend_kana;
    logic       r_shift;
    logic       n_pend_valid;
    logic [7:0] n_pend_kana;
    logic       n_shift;

    logic       w_accept;
    logic [7:0] w_byte;
    logic [7:0] w_pend_diff;
    logic       w_is_kana;
    logic       w_use_kana;
    logic       w_is_prefix;
    logic       w_takes_voice;
    logic       w_takes_semi;
    t_op        w_op;

    assign w_accept   = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;
    assign w_byte     = i_in_data.code_byte;
    assign w_pend_diff = r_pend_kana - KANA_LO;

    // Byte classes for the current mode.
    assign w_is_kana   = (w_byte >= KANA_LO) && (w_byte <= KANA_HI);
    assign w_use_kana  = w_is_kana && (!r_mode || r_shift);
    assign w_is_prefix = r_mode && !r_shift && (w_byte == BYTE_PREFIX);

    // Marks that the held kana accepts.
    assign w_takes_voice = ((r_pend_kana >= VOICE_A_LO) && (r_pend_kana <= VOICE_A_HI))
                        || ((r_pend_kana >= VOICE_B_LO) && (r_pend_kana <= VOICE_B_HI))
                        || (r_pend_kana == KANA_U);
    assign w_takes_semi  = (r_pend_kana >= VOICE_B_LO) && (r_pend_kana <= VOICE_B_HI);

    // Decide the work for this item and the next held state.
    always_comb begin
        n_pend_valid    = r_pend_valid;
        n_pend_kana     = r_pend_kana;
        n_shift         = r_shift;
        w_op.has_kana   = 1'b0;
        w_op.kana_idx   = w_pend_diff[5:0];
        w_op.mark       = MARK_NONE;
        w_op.has_bad    = 1'b0;
        w_op.bad_byte   = w_byte;
        if (i_in_data.kind == KIND_END) begin
            w_op.has_kana = r_pend_valid;
            w_op.has_bad  = r_shift;
            w_op.bad_byte = BYTE_PREFIX;
            n_pend_valid  = 1'b0;
            n_pend_kana   = '0;
            n_shift       = 1'b0;
        end else begin
            n_shift = w_is_prefix;
            if (w_use_kana) begin
                if (r_pend_valid && (w_byte == BYTE_VOICE) && w_takes_voice) begin
                    w_op.has_kana = 1'b1;
                    w_op.mark     = MARK_VOICE;
                    n_pend_valid  = 1'b0;
                    n_pend_kana   = '0;
                end else if (r_pend_valid && (w_byte == BYTE_SEMI) && w_takes_semi) begin
                    w_op.has_kana = 1'b1;
                    w_op.mark     = MARK_SEMI;
                    n_pend_valid  = 1'b0;
                    n_pend_kana   = '0;
                end else begin
                    w_op.has_kana = r_pend_valid;
                    n_pend_valid  = 1'b1;
                    n_pend_kana   = w_byte;
                end
            end else if (!w_is_prefix) begin
                w_op.has_kana = r_pend_valid;
                w_op.has_bad  = 1'b1;
                n_pend_valid  = 1'b0;
                n_pend_kana   = '0;
            end
        end
    end

    assign o_op   = w_op;
    assign o_push = w_accept && (w_op.has_kana || w_op.has_bad);

    // Mode register and held-kana state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_pend_kana  <= '0;
            r_shift      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (w_accept) begin
                r_pend_valid <= n_pend_valid;
                r_pend_kana  <= n_pend_kana;
                r_shift      <= n_shift;
            end
        end
    end

endmodule

// ===== design/hk2fw_queue.sv =====
// ----------------------------------------------------------------------------
// hk2fw_queue: work queue between the front and back parts
// A small register FIFO of pending work entries with a count of occupancy.
// ----------------------------------------------------------------------------
module hk2fw_queue
    import hk2fw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_op  o_head
);

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Pointer wrap and occupancy update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    // Queue control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== design/hk2fw_back.sv =====
// ----------------------------------------------------------------------------
// hk2fw_back: table lookup and result output
// Takes work from the queue, maps the kana through the full-width table,
// folds in the voicing mark and delivers one or two result items.
// ----------------------------------------------------------------------------
module hk2fw_back
    import hk2fw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_op       i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic       r_out_valid;
    t_out_item  r_out;
    logic       r_hold_bad;
    logic [7:0] r_hold_byte;
    logic       n_out_valid;
    t_out_item  n_out;
    logic       n_hold_bad;
    logic [7:0] n_hold_byte;

    logic       w_out_free;
    logic [7:0] w_lead;
    logic [7:0] w_trail_base;
    logic [7:0] w_trail;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_pop      = w_out_free && !r_hold_bad && !i_empty;

    // Table lookup and mark folding for the head entry.
    assign w_lead       = kana_lead(i_head.kana_idx);
    assign w_trail_base = kana_trail(i_head.kana_idx);

    always_comb begin
        w_trail = w_trail_base;
        case (i_head.mark)
            MARK_VOICE: begin
                if (((w_trail_base >= TRAIL_A_LO) && (w_trail_base <= TRAIL_A_HI))
                    || ((w_trail_base >= TRAIL_B_LO) && (w_trail_base <= TRAIL_B_HI))) begin
                    w_trail = w_trail_base + 8'd1;
                end else if ((w_lead == LEAD_KATA) && (w_trail_base == TRAIL_U)) begin
                    w_trail = TRAIL_VU;
                end
            end
            MARK_SEMI: begin
                if ((w_trail_base >= TRAIL_B_LO) && (w_trail_base <= TRAIL_B_HI)) begin
                    w_trail = w_trail_base + 8'd2;
                end
            end
            default: begin
                w_trail = w_trail_base;
            end
        endcase
    end

    // Output register loading; a flagged second result waits in the hold.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_hold_bad  = r_hold_bad;
        n_hold_byte = r_hold_byte;
        if (w_out_free) begin
            priority if (r_hold_bad) begin
                n_out_valid      = 1'b1;
                n_out.lead_byte  = r_hold_byte;
                n_out.trail_byte = '0;
                n_out.bad_byte   = 1'b1;
                n_out.last       = 1'b1;
                n_hold_bad       = 1'b0;
            end else if (!i_empty) begin
                n_out_valid = 1'b1;
                if (i_head.has_kana) begin
                    n_out.lead_byte  = w_lead;
                    n_out.trail_byte = w_trail;
                    n_out.bad_byte   = 1'b0;
                    n_out.last       = !i_head.has_bad;
                    n_hold_bad       = i_head.has_bad;
                    n_hold_byte      = i_head.bad_byte;
                end else begin
                    n_out.lead_byte  = i_head.bad_byte;
                    n_out.trail_byte = '0;
                    n_out.bad_byte   = 1'b1;
                    n_out.last       = 1'b1;
                end
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_out       <= n_out;
        r_hold_byte <= n_hold_byte;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hold_bad  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_hold_bad  <= n_hold_bad;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== design/halfwidth_kana_to_fullwidth.sv =====
// ----------------------------------------------------------------------------
// halfwidth_kana_to_fullwidth: half-width katakana to full-width Shift-JIS
// Converts a Shift-JIS or EUC half-width kana byte stream into full-width
// Shift-JIS pairs, folding voicing marks and flagging non-kana bytes.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                   Payload
//  input    in         i_in_valid / o_in_stall     i_in_data  (t_in_item)
//  output   out        o_out_valid / i_out_stall   o_out_data (t_out_item)
//  config   in         i_cfg_we                    i_cfg_data (encoding mode)
//
//  One input item is taken per cycle while the four-entry work queue has room.
//  Each result item sits in the output register; an item that causes two
//  results holds that register for both in turn, which the queue absorbs.
//  A result is presented once its work has passed through a queue entry and
//  then the output register.
//  Reset is synchronous and clears all control state; there is no clearing pass.
//  A stall on the output backs up the queue and then stalls the input.
// ----------------------------------------------------------------------------
module halfwidth_kana_to_fullwidth
    import hk2fw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_op  w_push_op;
    t_op  w_head_op;

    // Classification of incoming bytes.
    hk2fw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_op       (w_push_op)
    );

    // Work queue.
    hk2fw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head_op)
    );

    // Lookup and result delivery.
    hk2fw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_head      (w_head_op),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // The front never writes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("work pushed into a full queue");

    // The back never takes work from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_empty))
        else $error("work popped from an empty queue");

    // A flagged result always carries a zero trail byte.
    a_bad_trail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.bad_byte) |-> (o_out_data.trail_byte == 8'd0))
        else $error("flagged item with nonzero trail byte");

    // A result that is not the last of its input is always followed by more.
    a_last_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_data.last) |=> o_out_valid)
        else $error("second result of an item missing");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for halfwidth_kana_to_fullwidth
// Drives byte streams in both encodings, folds the expected voicing marks in
// a bench-side converter, and compares every result item field by field.
// A short scripted stream comes first, then random kana sequences in phases
// that switch the encoding, with random gaps, stalls and one long output hold
// per phase that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;
    import hk2fw_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 64;
    localparam int BURST_ITEMS   = 24;
    localparam int PHASE_ITEMS   = 92;
    localparam int PHASE_COUNT   = 6;
    // Encoding per random phase, phase 0 in bit 0.
    localparam logic [5:0] PHASE_MODES = 6'b010110;

    // Half-width stream bytes.
    localparam logic [7:0] HW_FIRST = 8'd161;
    localparam logic [7:0] HW_LAST  = 8'd223;
    localparam logic [7:0] HW_VOICE = 8'd222;
    localparam logic [7:0] HW_SEMI  = 8'd223;
    localparam logic [7:0] HW_U     = 8'd179;
    localparam logic [7:0] EUC_SS2  = 8'd142;

    // Kana ranges that accept marks, and the trail ranges that marks shift.
    localparam logic [7:0] VOICED_A_LO = 8'd182;
    localparam logic [7:0] VOICED_A_HI = 8'd196;
    localparam logic [7:0] VOICED_B_LO = 8'd202;
    localparam logic [7:0] VOICED_B_HI = 8'd206;
    localparam logic [7:0] SHIFT_A_LO  = 8'd74;
    localparam logic [7:0] SHIFT_A_HI  = 8'd103;
    localparam logic [7:0] SHIFT_B_LO  = 8'd110;
    localparam logic [7:0] SHIFT_B_HI  = 8'd122;
    localparam logic [7:0] FW_KATA     = 8'd131;
    localparam logic [7:0] FW_U_TRAIL  = 8'd69;
    localparam logic [7:0] FW_VU_TRAIL = 8'd148;

    // Full-width Shift-JIS pair for each half-width kana, first kana at index 0.
    localparam logic [0:62][7:0] FW_LEAD = {
        8'd129, 8'd129, 8'd129, 8'd129, 8'd129, 8'd131, 8'd131, 8'd131,
        8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd129,
        8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131,
        8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131,
        8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131,
        8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131,
        8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd131,
        8'd131, 8'd131, 8'd131, 8'd131, 8'd131, 8'd129, 8'd129
    };
    localparam logic [0:62][7:0] FW_TRAIL = {
        8'd66,  8'd117, 8'd118, 8'd65,  8'd69,  8'd146, 8'd64,  8'd66,
        8'd68,  8'd70,  8'd72,  8'd131, 8'd133, 8'd135, 8'd98,  8'd91,
        8'd65,  8'd67,  8'd69,  8'd71,  8'd73,  8'd74,  8'd76,  8'd78,
        8'd80,  8'd82,  8'd84,  8'd86,  8'd88,  8'd90,  8'd92,  8'd94,
        8'd96,  8'd99,  8'd101, 8'd103, 8'd105, 8'd106, 8'd107, 8'd108,
        8'd109, 8'd110, 8'd113, 8'd116, 8'd119, 8'd122, 8'd125, 8'd126,
        8'd128, 8'd129, 8'd130, 8'd132, 8'd134, 8'd136, 8'd137, 8'd138,
        8'd139, 8'd140, 8'd141, 8'd143, 8'd147, 8'd74,  8'd75
    };

    // One line of the scripted stream: an item or an encoding change.
    typedef enum logic {
        ROW_ITEM,
        ROW_MODE
    } t_row_op;

    typedef struct packed {
        t_row_op    op;
        t_in_item   item;
        logic       typed;
        logic [1:0] n_exp;
        t_out_item  r0;
        t_out_item  r1;
    } t_script_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_cfg_we    = 1'b0;
    logic      i_cfg_data  = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    // Bench copy of the converter state and the encoding register.
    logic [7:0] held_kana   = '0;
    logic       held_valid  = 1'b0;
    logic       prefix_seen = 1'b0;
    logic       euc_mode    = 1'b0;

    t_out_item   converted[$];
    t_out_item   expected_pairs[$];
    t_script_row script[$];

    int  mismatches  = 0;
    int  cycle_count = 0;
    int  items_sent  = 0;
    int  burst_left  = 0;
    bit  hold_req    = 1'b0;

    halfwidth_kana_to_fullwidth DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** halfwidth_kana_to_fullwidth: FAILED **");
            $finish;
        end
    end

    // Full-width pair of a half-width kana, with an optional mark folded in.
    function automatic t_out_item fullwidth_of(logic [7:0] k, t_mark mark);
        t_out_item r;
        int        idx;
        idx = (k >= HW_FIRST && k <= HW_LAST) ? int'(k - HW_FIRST) : 0;
        r.lead_byte  = FW_LEAD[idx];
        r.trail_byte = FW_TRAIL[idx];
        r.bad_byte   = 1'b0;
        r.last       = 1'b0;
        if (mark == MARK_VOICE) begin
            if ((r.trail_byte >= SHIFT_A_LO && r.trail_byte <= SHIFT_A_HI) ||
                (r.trail_byte >= SHIFT_B_LO && r.trail_byte <= SHIFT_B_HI)) begin
                r.trail_byte = r.trail_byte + 8'd1;
            end else if (r.lead_byte == FW_KATA && r.trail_byte == FW_U_TRAIL) begin
                r.trail_byte = FW_VU_TRAIL;
            end
        end else if (mark == MARK_SEMI &&
                     r.trail_byte >= SHIFT_B_LO && r.trail_byte <= SHIFT_B_HI) begin
            r.trail_byte = r.trail_byte + 8'd2;
        end
        return r;
    endfunction

    function automatic void release_held(t_mark mark);
        converted.push_back(fullwidth_of(held_kana, mark));
        held_valid = 1'b0;
        held_kana  = '0;
    endfunction

    function automatic void flag_byte(logic [7:0] b);
        t_out_item r;
        r.lead_byte  = b;
        r.trail_byte = 8'd0;
        r.bad_byte   = 1'b1;
        r.last       = 1'b0;
        converted.push_back(r);
    endfunction

    // A kana either completes the held one with its mark or takes its place.
    function automatic void take_kana(logic [7:0] b);
        logic voiceable;
        logic semi_able;
        voiceable = (held_kana >= VOICED_A_LO && held_kana <= VOICED_A_HI) ||
                    (held_kana >= VOICED_B_LO && held_kana <= VOICED_B_HI) ||
                    held_kana == HW_U;
        semi_able = held_kana >= VOICED_B_LO && held_kana <= VOICED_B_HI;
        if (held_valid) begin
            if (b == HW_VOICE && voiceable) begin
                release_held(MARK_VOICE);
                return;
            end
            if (b == HW_SEMI && semi_able) begin
                release_held(MARK_SEMI);
                return;
            end
            release_held(MARK_NONE);
        end
        held_kana  = b;
        held_valid = 1'b1;
    endfunction

    function automatic void take_bad(logic [7:0] b);
        if (held_valid) begin
            release_held(MARK_NONE);
        end
        flag_byte(b);
    endfunction

    // Results that one accepted item causes, left in converted.
    function automatic void convert_step(t_in_item it);
        t_out_item r;
        logic      is_kana;
        converted.delete();
        is_kana = it.code_byte >= HW_FIRST && it.code_byte <= HW_LAST;
        if (it.kind == KIND_END) begin
            if (held_valid) begin
                release_held(MARK_NONE);
            end
            if (prefix_seen) begin
                flag_byte(EUC_SS2);
            end
            prefix_seen = 1'b0;
            held_valid  = 1'b0;
            held_kana   = '0;
        end else if (!euc_mode || prefix_seen) begin
            prefix_seen = 1'b0;
            if (is_kana) begin
                take_kana(it.code_byte);
            end else begin
                take_bad(it.code_byte);
            end
        end else if (it.code_byte == EUC_SS2) begin
            prefix_seen = 1'b1;
        end else begin
            take_bad(it.code_byte);
        end
        if (converted.size() > 0) begin
            r = converted.pop_back();
            r.last = 1'b1;
            converted.push_back(r);
        end
    endfunction

    // Script line constructors.
    function automatic t_script_row make_row(t_row_op op, logic kind, logic [7:0] b,
                                             logic typed, logic [1:0] n_exp,
                                             t_out_item r0);
        t_script_row row;
        row.op             = op;
        row.item.kind      = kind;
        row.item.code_byte = b;
        row.typed          = typed;
        row.n_exp          = n_exp;
        row.r0             = r0;
        row.r1             = '0;
        return row;
    endfunction

    function automatic t_script_row row_byte(logic [7:0] b);
        return make_row(ROW_ITEM, KIND_DATA, b, 1'b0, 2'd0, '0);
    endfunction

    function automatic t_script_row row_end(logic [7:0] b);
        return make_row(ROW_ITEM, KIND_END, b, 1'b0, 2'd0, '0);
    endfunction

    function automatic t_script_row row_quiet(logic kind, logic [7:0] b);
        return make_row(ROW_ITEM, kind, b, 1'b1, 2'd0, '0);
    endfunction

    function automatic t_script_row row_one(logic kind, logic [7:0] b, logic [7:0] lead,
                                            logic [7:0] trail, logic bad);
        t_out_item r;
        r.lead_byte  = lead;
        r.trail_byte = trail;
        r.bad_byte   = bad;
        r.last       = 1'b1;
        return make_row(ROW_ITEM, kind, b, 1'b1, 2'd1, r);
    endfunction

    function automatic t_script_row row_mode(logic m);
        return make_row(ROW_MODE, KIND_DATA, {7'd0, m}, 1'b0, 2'd0, '0);
    endfunction

    // Input gap: mostly none or short, a few long; none during a burst.
    function automatic int input_gap();
        int r;
        if (burst_left > 0) begin
            burst_left = burst_left - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 25);
    endfunction

    // Offer one item, and on acceptance queue what it should produce.
    task automatic apply_item(t_script_row row);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= row.item;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        items_sent = items_sent + 1;
        convert_step(row.item);
        if (row.typed) begin
            if (row.n_exp > 2'd0) begin
                expected_pairs.push_back(row.r0);
            end
            if (row.n_exp > 2'd1) begin
                expected_pairs.push_back(row.r1);
            end
        end else begin
            foreach (converted[k]) begin
                expected_pairs.push_back(converted[k]);
            end
        end
        gap = input_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Change the encoding once the block has gone quiet.
    task automatic set_encoding(logic m);
        i_in_valid <= 1'b0;
        while (expected_pairs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        euc_mode = m;
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] random_kana();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(HW_FIRST, HW_LAST));
            1:       return 8'($urandom_range(VOICED_A_LO, VOICED_A_HI));
            2:       return 8'($urandom_range(VOICED_B_LO, VOICED_B_HI));
            default: return HW_U;
        endcase
    endfunction

    function automatic logic [7:0] random_mark();
        return $urandom_range(0, 1) ? HW_VOICE : HW_SEMI;
    endfunction

    // One random piece of stream, mostly well-formed for the current encoding.
    task automatic send_random_piece();
        int r;
        r = $urandom_range(0, 99);
        if (!euc_mode) begin
            if (r < 55) begin
                apply_item(row_byte(random_kana()));
            end else if (r < 80) begin
                apply_item(row_byte(random_mark()));
            end else if (r < 93) begin
                apply_item(row_byte(8'($urandom_range(0, 255))));
            end else begin
                apply_item(row_end(8'($urandom_range(0, 255))));
            end
        end else begin
            if (r < 55) begin
                apply_item(row_byte(EUC_SS2));
                apply_item(row_byte(random_kana()));
            end else if (r < 78) begin
                apply_item(row_byte(EUC_SS2));
                apply_item(row_byte(random_mark()));
            end else if (r < 86) begin
                apply_item(row_byte(8'($urandom_range(0, 255))));
            end else if (r < 93) begin
                apply_item(row_byte(EUC_SS2));
                apply_item(row_byte(8'($urandom_range(0, 255))));
            end else begin
                apply_item(row_end(8'($urandom_range(0, 255))));
            end
        end
    endtask

    // Compare one accepted result against the oldest expectation.
    task automatic check_result(t_out_item got);
        t_out_item want;
        if (expected_pairs.size() == 0) begin
            $display("%0t: unexpected result, expected none, %s%0d trail=%0d bad=%0d last=%0d",
                     $time, "actual lead=", got.lead_byte, got.trail_byte,
                     got.bad_byte, got.last);
            mismatches = mismatches + 1;
        end else begin
            want = expected_pairs.pop_front();
            if (got.lead_byte !== want.lead_byte) begin
                $display("%0t: lead_byte expected %0d, actual %0d",
                         $time, want.lead_byte, got.lead_byte);
                mismatches = mismatches + 1;
            end
            if (got.trail_byte !== want.trail_byte) begin
                $display("%0t: trail_byte expected %0d, actual %0d",
                         $time, want.trail_byte, got.trail_byte);
                mismatches = mismatches + 1;
            end
            if (got.bad_byte !== want.bad_byte) begin
                $display("%0t: bad_byte expected %0d, actual %0d",
                         $time, want.bad_byte, got.bad_byte);
                mismatches = mismatches + 1;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %0d, actual %0d",
                         $time, want.last, got.last);
                mismatches = mismatches + 1;
            end
        end
    endtask

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_result(o_out_data);
        end
    end

    // Output stall pattern, plus the long hold-off when asked for.
    initial begin
        int r;
        int n;
        int k;
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    i_out_stall <= 1'b0;
                    n = $urandom_range(1, 20);
                end else if (r < 92) begin
                    i_out_stall <= 1'b1;
                    n = $urandom_range(1, 3);
                end else begin
                    i_out_stall <= 1'b1;
                    n = $urandom_range(8, 40);
                end
                k = 0;
                do begin
                    @(posedge i_clk);
                    k = k + 1;
                end while (k < n && !hold_req);
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int phase;
        int start;
        bit held_off;

        // Scripted stream, starting in Shift-JIS mode straight from reset.
        script.push_back(row_one(KIND_DATA, 8'd0, 8'd0, 8'd0, 1'b1));
        script.push_back(row_one(KIND_DATA, 8'd255, 8'd255, 8'd0, 1'b1));
        script.push_back(row_quiet(KIND_END, 8'd0));
        script.push_back(row_quiet(KIND_DATA, HW_FIRST));
        // Semi-voicing mark that the held kana refuses: it becomes the held kana.
        script.push_back(row_one(KIND_DATA, HW_SEMI, 8'd129, 8'd66, 1'b0));
        script.push_back(row_one(KIND_END, 8'd255, 8'd129, 8'd75, 1'b0));
        script.push_back(row_quiet(KIND_DATA, 8'd182));
        script.push_back(row_one(KIND_DATA, HW_VOICE, 8'd131, 8'd75, 1'b0));
        script.push_back(row_quiet(KIND_DATA, 8'd202));
        script.push_back(row_one(KIND_DATA, HW_SEMI, 8'd131, 8'd112, 1'b0));
        // Voiced u turns into vu.
        script.push_back(row_quiet(KIND_DATA, HW_U));
        script.push_back(row_one(KIND_DATA, HW_VOICE, 8'd131, 8'd148, 1'b0));
        // A mark with nothing held, then a second one it cannot take.
        script.push_back(row_quiet(KIND_DATA, HW_VOICE));
        script.push_back(row_byte(HW_VOICE));
        // The prefix byte is an ordinary bad byte here, after a flush.
        script.push_back(row_byte(EUC_SS2));
        script.push_back(row_mode(1'b1));
        // Raw kana without a prefix is flagged in EUC.
        script.push_back(row_one(KIND_DATA, 8'd180, 8'd180, 8'd0, 1'b1));
        script.push_back(row_quiet(KIND_DATA, EUC_SS2));
        script.push_back(row_quiet(KIND_DATA, 8'd182));
        script.push_back(row_quiet(KIND_DATA, EUC_SS2));
        script.push_back(row_one(KIND_DATA, HW_VOICE, 8'd131, 8'd75, 1'b0));
        script.push_back(row_quiet(KIND_DATA, EUC_SS2));
        script.push_back(row_quiet(KIND_DATA, 8'd190));
        // Prefix then a non-kana byte: flush the held kana, flag the byte.
        script.push_back(row_quiet(KIND_DATA, EUC_SS2));
        script.push_back(row_byte(8'd65));
        // Dangling prefix at end of stream.
        script.push_back(row_quiet(KIND_DATA, EUC_SS2));
        script.push_back(row_one(KIND_END, 8'd0, EUC_SS2, 8'd0, 1'b1));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].op == ROW_MODE) begin
                set_encoding(script[i].item.code_byte[0]);
            end else begin
                apply_item(script[i]);
            end
        end

        // Random phases, each with one long output hold during an input burst.
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            set_encoding(PHASE_MODES[phase]);
            start    = items_sent;
            held_off = 1'b0;
            while (items_sent - start < PHASE_ITEMS) begin
                if (!held_off && items_sent - start >= 30) begin
                    burst_left = BURST_ITEMS;
                    hold_req   = 1'b1;
                    held_off   = 1'b1;
                end
                send_random_piece();
            end
        end

        i_in_valid <= 1'b0;
        while (expected_pairs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_pairs.size() == 0) begin
            $display("** halfwidth_kana_to_fullwidth: PASSED **");
        end else begin
            $display("** halfwidth_kana_to_fullwidth: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/hk2fw_pkg.sv
design/hk2fw_front.sv
design/hk2fw_queue.sv
design/hk2fw_back.sv
design/halfwidth_kana_to_fullwidth.sv
tb/tb_top.sv
